// ===== src/cdr_pkg.sv =====
// shared constants and sequencer state type for the cepstral delta regression block
`default_nettype none

package cdr_pkg;

  // default configuration
  localparam int BANDS_DEF      = 32;
  localparam int DELTA_HALF_DEF = 2;

  // fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int BAND_W      = 5;
  localparam int FBACK_W     = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // output clamp limits
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GATHER,
    ST_HI,
    ST_LO,
    ST_ACC,
    ST_DX,
    ST_DQ,
    ST_DR,
    ST_EMIT,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== src/cdr_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module cdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/cdr_mul.sv =====
// shared signed multiplier with registered product
`default_nettype none

module cdr_mul #(
  parameter int A_W = 24,
  parameter int B_W = 23
) (
  input  logic                        clk,
  input  logic signed [A_W-1:0]       a,
  input  logic signed [B_W-1:0]       b,
  output logic signed [A_W+B_W-1:0]   prod
);

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// ===== src/cepstral_delta_regression.sv =====
// top level: per-band delta regression over a stored frame history
// Usage: one coefficient word enters on the s_ channel (sample, band, first-frame
// flag in s_tuser, last-frame mark in s_tlast). Each band keeps its last 2N
// samples in a ram, with a per-band write pointer and frame count.
// A word of frame i >= N yields one delta for frame i-N; a last-frame word yields
// the deltas of every frame still owed, oldest first, the final one with m_tlast.
// Words with a band of BANDS or more are taken and dropped.
// Sequencing: a word first reads back its F stored frames (up to 2N, one ram read
// a cycle), then for each of its results makes N multiply-accumulate passes through
// the one shared multiplier, followed by a reciprocal multiply, a back multiply and
// a correction step. s_tready is high only while the sequencer is idle.
// A result sits in the output register until taken; the sequencer stops before
// loading the next one while that register is full and m_tready is low, and accepts no new word meanwhile.
// Reset clears frame counts, pointers and the output valid; no ram sweep.
`default_nettype none

module cepstral_delta_regression #(
  parameter int BANDS      = cdr_pkg::BANDS_DEF,
  parameter int DELTA_HALF = cdr_pkg::DELTA_HALF_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cdr_pkg::IN_TDATA_W-1:0]  s_tdata,   // sample[15:0], band[20:16], zero pad
  input  logic                            s_tuser,   // first_frame
  input  logic                            s_tlast,   // last_frame
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cdr_pkg::OUT_TDATA_W-1:0] m_tdata,   // delta[15:0], band_out[20:16],
                                                     // frames_back[23:21]
  output logic                            m_tlast    // last
);

  import cdr_pkg::*;

  localparam int WIN    = 2 * DELTA_HALF;
  localparam int SLOT_W = $clog2(WIN);
  localparam int PW     = $clog2(WIN + 1);
  localparam int FS_W   = PW;
  localparam int KW     = $clog2(DELTA_HALF + 1);
  localparam int EW     = $clog2(2 * WIN + 1);
  localparam int IDX_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int EXT_W  = (IDX_W > BAND_W) ? IDX_W : BAND_W;
  localparam int DEPTH  = BANDS * WIN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TRI    = DELTA_HALF * (DELTA_HALF + 1) / 2;
  localparam int NUM_W  = SAMPLE_W + 2 + $clog2(TRI + 1);
  localparam int DEN    = DELTA_HALF * (DELTA_HALF + 1) * (2 * DELTA_HALF + 1) / 3;
  localparam int DV     = 2 * DEN;
  localparam int X_W    = NUM_W + 1;
  localparam int Q_W    = X_W - 1;
  localparam int SH     = X_W;
  localparam int MA_W   = X_W + 1;
  localparam int MB_W   = SH;
  localparam int P_W    = MA_W + MB_W;
  localparam longint RECIP = (longint'(1) << SH) / DV;

  // sequencer state
  state_t state, state_next;

  // per-band control state
  logic [FS_W-1:0]   frames_seen [BANDS];
  logic [SLOT_W-1:0] ptr [BANDS];

  // item registers
  logic signed [SAMPLE_W-1:0] cur;
  logic [BAND_W-1:0]          band_r;
  logic [IDX_W-1:0]           bidx;
  logic                       lastf;
  logic [FS_W-1:0]            fs;
  logic [SLOT_W-1:0]          ptr_cur;
  logic [PW-1:0]              j;
  logic [PW-1:0]              p;
  logic [PW-1:0]              p_end;
  logic [KW-1:0]              k;

  // window of gathered history, newest first
  logic signed [SAMPLE_W-1:0] h [WIN];
  logic                       cap_en;
  logic [SLOT_W-1:0]          cap_j;

  // arithmetic registers
  logic signed [SAMPLE_W-1:0] hv;
  logic signed [NUM_W-1:0]    acc;
  logic                       acc_en;
  logic                       neg;
  logic [X_W-1:0]             xq;
  logic [Q_W-1:0]             q0;
  logic signed [SAMPLE_W-1:0] res;

  // shared multiplier and ram hookup
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  mprod;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [SAMPLE_W-1:0]    ram_rdata;

  // combinational helpers
  logic                       accept;
  logic [SAMPLE_W-1:0]        in_sample;
  logic [BAND_W-1:0]          in_band;
  logic [EXT_W-1:0]           band_ext;
  logic [IDX_W-1:0]           in_idx;
  logic                       in_range;
  logic                       rd_issue;
  logic                       out_free;
  logic                       out_load;
  logic [SLOT_W-1:0]          j_s;
  logic [SLOT_W-1:0]          rslot;
  logic [SLOT_W-1:0]          wslot;
  logic [ADDR_W-1:0]          base;
  logic [PW-1:0]              floor_p;
  logic [PW-1:0]              start_p;
  logic                       has_res;
  logic [FS_W-1:0]            fs_upd;
  logic [EW-1:0]              p_e, k_e, hi_raw, hi_pos, lo_pos, sel_pos, floor_pos, eff_pos;
  logic [EW-1:0]              h_full;
  logic [SLOT_W-1:0]          h_idx;
  logic signed [SAMPLE_W-1:0] win_v;
  logic signed [SAMPLE_W:0]   diff;
  logic [NUM_W-1:0]           acc_mag;
  logic [X_W-1:0]             x_c;
  logic [Q_W-1:0]             q0_c;
  logic [X_W:0]               r_c;
  logic [Q_W-1:0]             q_c;
  logic signed [SAMPLE_W-1:0] res_c;
  logic [PW-1:0]              fb_full;

  // input decode
  assign in_sample = s_tdata[SAMPLE_W-1:0];
  assign in_band   = s_tdata[SAMPLE_W +: BAND_W];
  assign band_ext  = EXT_W'(in_band);
  assign in_idx    = band_ext[IDX_W-1:0];
  assign in_range  = (int'(in_band) < BANDS);
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid & s_tready;

  // ram addressing, history j sits at slot ptr - j modulo the window
  assign j_s   = j[SLOT_W-1:0];
  assign rslot = (ptr_cur >= j_s) ? (ptr_cur - j_s) : (ptr_cur + SLOT_W'(WIN) - j_s);
  assign wslot = (ptr_cur == SLOT_W'(WIN - 1)) ? '0 : (ptr_cur + 1'b1);
  assign base      = ADDR_W'(bidx) * ADDR_W'(WIN);
  assign ram_raddr = base + ADDR_W'(rslot);
  assign ram_waddr = base + ADDR_W'(wslot);

  // result range for this word
  assign floor_p = PW'(WIN) - fs;
  assign start_p = (lastf && (floor_p > PW'(DELTA_HALF))) ? floor_p : PW'(DELTA_HALF);
  assign has_res = lastf || (fs >= FS_W'(DELTA_HALF));
  assign fs_upd  = lastf ? '0 : ((fs < FS_W'(WIN)) ? (fs + 1'b1) : FS_W'(WIN));

  // window read: clamp to the window ends, older frames repeat the first one
  assign p_e       = EW'(p);
  assign k_e       = EW'(k);
  assign hi_raw    = p_e + k_e;
  assign hi_pos    = (hi_raw > EW'(WIN)) ? EW'(WIN) : hi_raw;
  assign lo_pos    = (p_e >= k_e) ? (p_e - k_e) : '0;
  assign sel_pos   = (state == ST_HI) ? hi_pos : lo_pos;
  assign floor_pos = EW'(WIN) - EW'(fs);
  assign eff_pos   = (sel_pos < floor_pos) ? floor_pos : sel_pos;
  assign h_full    = EW'(WIN - 1) - eff_pos;
  assign h_idx     = h_full[SLOT_W-1:0];
  assign win_v     = (eff_pos == EW'(WIN)) ? cur : h[h_idx];
  assign diff      = {hv[SAMPLE_W-1], hv} - {win_v[SAMPLE_W-1], win_v};

  // rounding divide by reciprocal multiply and one correction
  assign acc_mag = acc[NUM_W-1] ? (-acc) : acc;
  assign x_c     = {acc_mag, 1'b0} + X_W'(DEN);
  assign q0_c    = mprod[SH +: Q_W];
  assign r_c     = {1'b0, xq} - mprod[X_W:0];
  assign q_c     = q0 + Q_W'(r_c >= (X_W + 1)'(DV));

  // sign and clamp
  always_comb begin
    if (!neg) begin
      res_c = (q_c > Q_W'(32767)) ? SAMPLE_MAX : $signed(q_c[SAMPLE_W-1:0]);
    end else begin
      res_c = (q_c > Q_W'(32768)) ? SAMPLE_MIN : (16'sh0 - $signed(q_c[SAMPLE_W-1:0]));
    end
  end

  // output register handshake
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_EMIT) && out_free;
  assign fb_full  = PW'(WIN) - p;

  // next state and unit controls
  always_comb begin
    state_next = state;
    rd_issue   = 1'b0;
    ram_we     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_range) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (j < fs) begin
          rd_issue = 1'b1;
        end else if (has_res) begin
          state_next = ST_HI;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_HI: begin
        state_next = ST_LO;
      end
      ST_LO: begin
        mul_a = {{(MA_W-SAMPLE_W-1){diff[SAMPLE_W]}}, diff};
        mul_b = {{(MB_W-KW){1'b0}}, k};
        state_next = (k == KW'(DELTA_HALF)) ? ST_ACC : ST_HI;
      end
      ST_ACC: begin
        state_next = ST_DX;
      end
      ST_DX: begin
        mul_a = {1'b0, x_c};
        mul_b = MB_W'(RECIP);
        state_next = ST_DQ;
      end
      ST_DQ: begin
        mul_a = {{(MA_W-Q_W){1'b0}}, q0_c};
        mul_b = MB_W'(DV);
        state_next = ST_DR;
      end
      ST_DR: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (p == p_end) ? ST_FIN : ST_HI;
        end
      end
      ST_FIN: begin
        ram_we     = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers: frame counts, pointers, strobes, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BANDS; i++) begin
        frames_seen[i] <= '0;
        ptr[i]         <= '0;
      end
      acc_en   <= 1'b0;
      cap_en   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      acc_en <= (state == ST_LO);
      cap_en <= rd_issue;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_FIN) begin
        frames_seen[bidx] <= fs_upd;
        ptr[bidx]         <= wslot;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cap_j <= j_s;
    if (cap_en) begin
      h[cap_j] <= $signed(ram_rdata);
    end
    if ((state == ST_HI) && (k == KW'(1))) begin
      acc <= '0;
    end else if (acc_en) begin
      acc <= acc + mprod[NUM_W-1:0];
    end
    unique case (state)
      ST_IDLE: begin
        cur     <= $signed(in_sample);
        band_r  <= in_band;
        bidx    <= in_idx;
        lastf   <= s_tlast;
        fs      <= s_tuser ? '0 : frames_seen[in_idx];
        ptr_cur <= ptr[in_idx];
        j       <= '0;
      end
      ST_GATHER: begin
        if (j < fs) begin
          j <= j + 1'b1;
        end else begin
          p     <= start_p;
          p_end <= lastf ? PW'(WIN) : PW'(DELTA_HALF);
          k     <= KW'(1);
        end
      end
      ST_HI: begin
        hv <= win_v;
      end
      ST_LO: begin
        if (k != KW'(DELTA_HALF)) begin
          k <= k + 1'b1;
        end
      end
      ST_DX: begin
        xq  <= x_c;
        neg <= acc[NUM_W-1];
      end
      ST_DQ: begin
        q0 <= q0_c;
      end
      ST_DR: begin
        res <= res_c;
      end
      ST_EMIT: begin
        if (out_free) begin
          m_tdata <= {FBACK_W'(fb_full), band_r, res};
          m_tlast <= (p == p_end);
          p       <= p + 1'b1;
          k       <= KW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // shared multiplier
  cdr_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mprod)
  );

  // per-band sample history
  cdr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cur),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== tb/cepstral_delta_regression_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the cepstral delta regression block
module cepstral_delta_regression_tb;
  import cdr_pkg::*;

  localparam int NB  = BANDS_DEF;
  localparam int NH  = DELTA_HALF_DEF;
  localparam int WIN = 2 * NH;

  // one coefficient word as offered to the block
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [BAND_W-1:0]   band;
    logic                first_frame;
    logic                last_frame;
    logic                drain;       // hold back until every delta has arrived
  } coef_t;

  // one delta word as it should leave the block
  typedef struct packed {
    logic [SAMPLE_W-1:0] delta;
    logic [BAND_W-1:0]   band;
    logic [FBACK_W-1:0]  back;
    logic                last;
  } delta_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  coef_t  coef_words [$];
  delta_t deltas_due [$];
  coef_t  cur;
  int     errors = 0;
  int     words_in = 0;
  int     gap_s = 0;
  int     calm_s = 0;
  int     stall_r = 0;
  int     calm_r = 0;
  int     hold_left = 0;
  bit     long_done = 1'b0;

  // predictor state: sample history per band, newest first, and frames seen
  logic [SAMPLE_W-1:0] hist [NB][WIN];
  int                  seen [NB];
  int                  win_vals [0:WIN];

  cepstral_delta_regression u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  initial begin
    for (int b = 0; b < NB; b++) seen[b] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // regression slope at window position p, rounded half away from zero
  function automatic logic [SAMPLE_W-1:0] regress_at(input int p);
    longint num, den, mag, q;
    int hi, lo;
    num = 0;
    den = 0;
    for (int k = 1; k <= NH; k++) begin
      hi = (p + k > WIN) ? WIN : p + k;
      lo = (p - k < 0) ? 0 : p - k;
      num += longint'(k) * (longint'(win_vals[hi]) - longint'(win_vals[lo]));
      den += k * k;
    end
    den = den * 2;
    mag = (num < 0) ? -num : num;
    q = (mag * 2 + den) / (den * 2);
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SAMPLE_W-1:0];
  endfunction

  // work out the deltas one accepted word causes and advance the band history
  task automatic predict_word(input coef_t c);
    int b, fs, first_p;
    delta_t d;
    b = c.band;
    if (b >= NB) return;
    fs = c.first_frame ? 0 : seen[b];
    if (fs > WIN) fs = WIN;
    // frames older than the utterance repeat its first frame
    win_vals[WIN] = $signed(c.sample);
    for (int j = 0; j < WIN; j++)
      win_vals[WIN-1-j] = (j < fs) ? $signed(hist[b][j]) : win_vals[WIN-j];
    if (c.last_frame) begin
      first_p = (WIN - fs < NH) ? NH : WIN - fs;
      for (int p = first_p; p <= WIN; p++) begin
        d.delta = regress_at(p);
        d.band  = c.band;
        d.back  = FBACK_W'(WIN - p);
        d.last  = (p == WIN);
        deltas_due = {deltas_due, d};
      end
    end else if (fs >= NH) begin
      d.delta = regress_at(NH);
      d.band  = c.band;
      d.back  = FBACK_W'(NH);
      d.last  = 1'b1;
      deltas_due = {deltas_due, d};
    end
    for (int j = WIN - 1; j > 0; j--) hist[b][j] = hist[b][j-1];
    hist[b][0] = c.sample;
    seen[b] = c.last_frame ? 0 : ((fs < WIN) ? fs + 1 : WIN);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r == 2) return 16'h0000;
    return SAMPLE_W'($urandom);
  endfunction

  task automatic add_word(input logic [SAMPLE_W-1:0] s, input int b,
                          input bit ff, input bit lf, input bit dr);
    coef_t c;
    c.sample      = s;
    c.band        = BAND_W'(b);
    c.first_frame = ff;
    c.last_frame  = lf;
    c.drain       = dr;
    coef_words = {coef_words, c};
  endtask

  // driver: offer queued words, with random gaps and calm stretches
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_word(cur);
        words_in <= words_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_s > 0) begin
          gap_s--;
          s_tvalid <= 1'b0;
        end else if (coef_words.size() > 0 &&
                     !(coef_words[0].drain && deltas_due.size() > 0)) begin
          cur = coef_words.pop_front();
          s_tdata  <= {3'b000, cur.band, cur.sample};
          s_tuser  <= cur.first_frame;
          s_tlast  <= cur.last_frame;
          s_tvalid <= 1'b1;
          if (calm_s > 0) begin
            calm_s--;
            gap_s = 0;
          end else if ($urandom_range(0, 19) == 0) begin
            calm_s = 12;
            gap_s = 0;
          end else begin
            gap_s = pick_gap();
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each delta word and pace m_tready
  always @(posedge clk) begin
    delta_t exp_d;
    delta_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.delta = m_tdata[15:0];
        got.band  = m_tdata[20:16];
        got.back  = m_tdata[23:21];
        got.last  = m_tlast;
        if (deltas_due.size() == 0) begin
          report($sformatf("unexpected delta %h band %0d back %0d",
                           got.delta, got.band, got.back));
        end else begin
          exp_d = deltas_due.pop_front();
          if (got.delta !== exp_d.delta)
            report($sformatf("delta %h, wanted %h (band %0d back %0d)",
                             got.delta, exp_d.delta, exp_d.band, exp_d.back));
          if (got.band !== exp_d.band)
            report($sformatf("band %0d, wanted %0d", got.band, exp_d.band));
          if (got.back !== exp_d.back)
            report($sformatf("frames back %0d, wanted %0d (band %0d)",
                             got.back, exp_d.back, exp_d.band));
          if (got.last !== exp_d.last)
            report($sformatf("last %b, wanted %b (band %0d back %0d)",
                             got.last, exp_d.last, exp_d.band, exp_d.back));
        end
      end
      // one long hold-off so the block fills and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!long_done && words_in >= 30) begin
        long_done = 1'b1;
        hold_left = 400;
        m_tready <= 1'b0;
      end else if (calm_r > 0) begin
        calm_r--;
        m_tready <= 1'b1;
      end else if (stall_r > 0) begin
        stall_r--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 29) == 0) begin
        calm_r = 20;
        m_tready <= 1'b1;
      end else begin
        stall_r = pick_gap();
        m_tready <= (stall_r == 0);
      end
    end
  end

  // stimulus and end of run
  initial begin
    int left [NB];
    int pool [4];
    int b, r;
    bit ff, lf;

    for (int i = 0; i < NB; i++) left[i] = 0;

    // single-frame utterance gives a zero delta
    add_word(16'h7FFF, 0, 1, 1, 0);
    // two-frame utterance on the top band
    add_word(16'h8000, 31, 1, 0, 0);
    add_word(16'h7FFF, 31, 0, 1, 0);
    // full-scale alternation, frame count saturating
    for (int i = 0; i < 6; i++)
      add_word((i % 2) ? 16'h7FFF : 16'h8000, 5, i == 0, i == 5, 0);
    // after the last frame the band restarts without a first-frame mark
    add_word(16'h1234, 5, 0, 0, 0);
    add_word(16'hFEDC, 5, 0, 1, 0);
    // first-frame mark in the middle of a running utterance
    add_word(16'd100, 10, 1, 0, 0);
    add_word(16'd200, 10, 0, 0, 0);
    add_word(16'd300, 10, 0, 0, 0);
    add_word(-16'sd5, 10, 1, 0, 0);
    add_word(16'd7, 10, 0, 0, 0);
    add_word(-16'sd9, 10, 0, 1, 0);
    // short utterance flushing the most results
    add_word(16'd1, 20, 1, 0, 0);
    add_word(16'd2, 20, 0, 0, 0);
    add_word(16'd3, 20, 0, 1, 0);
    add_word(16'h0000, 21, 1, 0, 0);
    add_word(16'hFFFF, 21, 0, 0, 0);
    add_word(16'h0001, 21, 0, 1, 0);

    // random part: interleaved utterances on a few bands, some noise
    for (int n = 0; n < 87; n++) begin
      if (n % 25 == 0)
        for (int i = 0; i < 4; i++) pool[i] = $urandom_range(0, NB - 1);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        b  = $urandom_range(0, NB - 1);
        ff = $urandom_range(0, 1);
        lf = ($urandom_range(0, 3) == 0);
      end else begin
        b = pool[$urandom_range(0, 3)];
        ff = 1'b0;
        if (left[b] == 0) begin
          left[b] = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30)
                                                : $urandom_range(1, 10);
          ff = ($urandom_range(0, 4) != 0);
        end
        lf = (left[b] == 1);
        left[b]--;
      end
      add_word(pick_sample(), b, ff, lf, n == 0 || n == 60);
    end

    @(negedge rst);
    while (coef_words.size() > 0 || s_tvalid || deltas_due.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (deltas_due.size() > 0)
      report($sformatf("%0d deltas never arrived", deltas_due.size()));
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
src/cdr_pkg.sv
src/cdr_ram.sv
src/cdr_mul.sv
src/cepstral_delta_regression.sv
tb/cepstral_delta_regression_tb.sv
